### hdl/scq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scq_pkg - shared types for the strict priority command queue
// Request and status codes, command and response items, queue entry, FSM.
// ----------------------------------------------------------------------------
package scq_pkg;

    typedef enum logic [2:0] {
        REQ_SUBMIT   = 3'd0,
        REQ_DISPATCH = 3'd1,
        REQ_WITHDRAW = 3'd2,
        REQ_FINISH   = 3'd3,
        REQ_ATTACH   = 3'd4,
        REQ_DETACH   = 3'd5
    } req_t;

    typedef enum logic [3:0] {
        ST_QUEUED     = 4'd0,
        ST_BYPASS     = 4'd1,
        ST_DROPPED    = 4'd2,
        ST_DISPATCHED = 4'd3,
        ST_OWNER_GONE = 4'd4,
        ST_EMPTY      = 4'd5,
        ST_WITHDRAWN  = 4'd6,
        ST_DONE       = 4'd7,
        ST_NOT_DONE   = 4'd8,
        ST_OWNER_UPD  = 4'd9
    } status_t;

    typedef struct packed {
        req_t       req_type;
        logic [4:0] priority_req;
        logic [4:0] inst_index;
        logic [1:0] core_index;
        logic [3:0] codec_mode;
        logic [5:0] owner_id;
    } cmd_t;

    typedef struct packed {
        status_t    status;
        logic [4:0] out_priority;
        logic [4:0] out_inst_index;
        logic [1:0] out_core_index;
        logic [3:0] out_codec_mode;
        logic [5:0] out_owner_id;
    } rsp_t;

    typedef struct packed {
        logic [4:0] inst;
        logic [1:0] core;
        logic [3:0] mode;
        logic [5:0] owner;
    } entry_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_POP  = 2'd2
    } state_t;

endpackage : scq_pkg
`default_nettype wire

### hdl/strict_priority_command_queue_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// strict_priority_command_queue_unit - per-level FIFO command scheduler
// One FIFO per priority level in a shared entry memory; dispatch serves the
// highest non-empty level, with owner and done-flag bookkeeping.
//
//   channel  | ports                 | handshake
//   ---------+-----------------------+------------------------------------
//   command  | start, busy, cmd      | taken when start && !busy
//   response | rsp_valid, rsp        | one-cycle strobe, cannot be stalled
//   config   | cfg_we, cfg_wdata     | prio_enable written when cfg_we
//
// Submit, finish, attach, detach, and dispatch or withdraw that find no
// entry: busy in the execute state, strobe in the next one.
// Dispatch and withdraw that pop an entry: busy in the execute and pop
// states, the pop state set by the registered read of the entry memory.
// Submit, dispatch and withdraw go through one pointer/count update unit, one at a time.
// The next command may be taken in the cycle its predecessor's strobe shows.
// Reset empties every level and clears done flags, owners and the first flag.
// ----------------------------------------------------------------------------
module strict_priority_command_queue_unit
    import scq_pkg::*;
#(
    parameter int NUM_LEVELS    = 32,
    parameter int LEVEL_DEPTH   = 8,
    parameter int NUM_INSTANCES = 32,
    parameter int NUM_OWNERS    = 64
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire cmd_t cmd,
    input  wire logic cfg_we,
    input  wire logic cfg_wdata,
    output logic      rsp_valid,
    output rsp_t      rsp
);

    localparam int LVL_W     = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int PTR_W     = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int CNT_W     = $clog2(LEVEL_DEPTH + 1);
    localparam int INST_W    = (NUM_INSTANCES > 1) ? $clog2(NUM_INSTANCES) : 1;
    localparam int OWN_W     = (NUM_OWNERS > 1) ? $clog2(NUM_OWNERS) : 1;
    localparam int MEM_DEPTH = NUM_LEVELS * (2 ** PTR_W);

    state_t                   state_reg, state_next;
    cmd_t                     cmd_reg;
    logic                     prio_enable_reg;
    logic                     first_seen_reg;
    logic [NUM_OWNERS-1:0]    owner_live_reg;
    logic [NUM_INSTANCES-1:0] done_reg  [NUM_LEVELS];
    logic [PTR_W-1:0]         head_reg  [NUM_LEVELS];
    logic [PTR_W-1:0]         tail_reg  [NUM_LEVELS];
    logic [CNT_W-1:0]         count_reg [NUM_LEVELS];
    entry_t                   mem       [MEM_DEPTH];
    entry_t                   rdata_reg;
    logic [LVL_W-1:0]         pop_lvl_reg;
    logic                     pop_disp_reg;
    rsp_t                     rsp_reg, rsp_next;
    logic                     rsp_valid_reg;

    logic                     lvl_ok, inst_ok, owner_ok;
    logic [LVL_W-1:0]         req_lvl, pe_lvl, sel_lvl;
    logic [INST_W-1:0]        fin_inst;
    logic [OWN_W-1:0]         own_idx;
    logic                     any_nonempty;
    logic                     unit_push;
    logic [PTR_W-1:0]         unit_ptr, unit_ptr_inc;
    logic [CNT_W-1:0]         count_cur, count_upd;
    logic                     level_full;
    logic                     pop_owner_live;
    logic                     do_push, do_pop, do_finish, do_attach, do_detach;
    logic                     set_first, set_done, rsp_load;
    entry_t                   wentry;

    assign busy      = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Decode and range checks on the held command
    assign lvl_ok   = (6'(cmd_reg.priority_req) < 6'(NUM_LEVELS));
    assign inst_ok  = (7'(cmd_reg.inst_index) < 7'(NUM_INSTANCES));
    assign owner_ok = (7'(cmd_reg.owner_id) < 7'(NUM_OWNERS));
    assign req_lvl  = LVL_W'(cmd_reg.priority_req);
    assign fin_inst = INST_W'(cmd_reg.inst_index);
    assign own_idx  = OWN_W'(cmd_reg.owner_id);

    // Highest non-empty level wins
    always_comb
    begin
        any_nonempty = 1'b0;
        pe_lvl       = '0;
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            if (count_reg[l] != '0)
            begin
                any_nonempty = 1'b1;
                pe_lvl       = LVL_W'(l);
            end
        end
    end

    assign sel_lvl = (cmd_reg.req_type == REQ_DISPATCH) ? pe_lvl : req_lvl;

    // Shared pointer/count unit: tail and count up on push, head and count down on pop
    assign unit_push    = (cmd_reg.req_type == REQ_SUBMIT);
    assign unit_ptr     = unit_push ? tail_reg[sel_lvl] : head_reg[sel_lvl];
    assign unit_ptr_inc = (unit_ptr == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : unit_ptr + 1'b1;
    assign count_cur    = count_reg[sel_lvl];
    assign count_upd    = unit_push ? count_cur + 1'b1 : count_cur - 1'b1;
    assign level_full   = (count_cur >= CNT_W'(LEVEL_DEPTH));

    assign wentry.inst  = cmd_reg.inst_index;
    assign wentry.core  = cmd_reg.core_index;
    assign wentry.mode  = cmd_reg.codec_mode;
    assign wentry.owner = cmd_reg.owner_id;

    assign pop_owner_live = (7'(rdata_reg.owner) < 7'(NUM_OWNERS))
                         && owner_live_reg[OWN_W'(rdata_reg.owner)];

    always_comb
    begin
        state_next = state_reg;
        do_push    = 1'b0;
        do_pop     = 1'b0;
        do_finish  = 1'b0;
        do_attach  = 1'b0;
        do_detach  = 1'b0;
        set_first  = 1'b0;
        set_done   = 1'b0;
        rsp_load   = 1'b0;
        rsp_next   = '0;
        rsp_next.status = ST_EMPTY;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                rsp_load   = 1'b1;
                unique case (cmd_reg.req_type)
                    REQ_SUBMIT:
                    begin
                        priority if (!(lvl_ok && inst_ok))
                        begin
                            rsp_next.status = ST_DROPPED;
                        end
                        else if (!first_seen_reg || !prio_enable_reg)
                        begin
                            set_first       = 1'b1;
                            rsp_next.status = ST_BYPASS;
                        end
                        else if (level_full)
                        begin
                            rsp_next.status = ST_DROPPED;
                        end
                        else
                        begin
                            do_push         = 1'b1;
                            rsp_next.status = ST_QUEUED;
                        end
                    end
                    REQ_DISPATCH:
                    begin
                        if (any_nonempty)
                        begin
                            do_pop     = 1'b1;
                            rsp_load   = 1'b0;
                            state_next = S_POP;
                        end
                    end
                    REQ_WITHDRAW:
                    begin
                        if (lvl_ok && (count_cur != '0))
                        begin
                            do_pop     = 1'b1;
                            rsp_load   = 1'b0;
                            state_next = S_POP;
                        end
                    end
                    REQ_FINISH:
                    begin
                        rsp_next.status = ST_NOT_DONE;
                        if (lvl_ok && inst_ok)
                        begin
                            do_finish = 1'b1;
                            if (done_reg[req_lvl][fin_inst])
                            begin
                                rsp_next.status = ST_DONE;
                            end
                        end
                    end
                    REQ_ATTACH:
                    begin
                        do_attach       = owner_ok;
                        rsp_next.status = ST_OWNER_UPD;
                    end
                    REQ_DETACH:
                    begin
                        do_detach       = owner_ok;
                        rsp_next.status = ST_OWNER_UPD;
                    end
                    default:
                    begin
                        rsp_next.status = ST_EMPTY;
                    end
                endcase
            end
            S_POP:
            begin
                state_next              = S_IDLE;
                rsp_load                = 1'b1;
                rsp_next.out_priority   = 5'(pop_lvl_reg);
                rsp_next.out_inst_index = rdata_reg.inst;
                rsp_next.out_core_index = rdata_reg.core;
                rsp_next.out_codec_mode = rdata_reg.mode;
                rsp_next.out_owner_id   = rdata_reg.owner;
                priority if (!pop_disp_reg)
                begin
                    rsp_next.status = ST_WITHDRAWN;
                end
                else if (pop_owner_live)
                begin
                    set_done        = 1'b1;
                    rsp_next.status = ST_DISPATCHED;
                end
                else
                begin
                    rsp_next.status = ST_OWNER_GONE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Entry memory: one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[{sel_lvl, unit_ptr}] <= wentry;
        end
        if (do_pop)
        begin
            rdata_reg <= mem[{sel_lvl, unit_ptr}];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= cmd;
        end
        if (do_pop)
        begin
            pop_lvl_reg  <= sel_lvl;
            pop_disp_reg <= (cmd_reg.req_type == REQ_DISPATCH);
        end
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prio_enable_reg <= 1'b0;
            first_seen_reg  <= 1'b0;
            owner_live_reg  <= '0;
            rsp_valid_reg   <= 1'b0;
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                done_reg[l]  <= '0;
                head_reg[l]  <= '0;
                tail_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
        end
        else
        begin
            rsp_valid_reg <= rsp_load;
            if (cfg_we)
            begin
                prio_enable_reg <= cfg_wdata;
            end
            if (set_first)
            begin
                first_seen_reg <= 1'b1;
            end
            if (do_attach)
            begin
                owner_live_reg[own_idx] <= 1'b1;
            end
            if (do_detach)
            begin
                owner_live_reg[own_idx] <= 1'b0;
            end
            if (do_push)
            begin
                tail_reg[sel_lvl]  <= unit_ptr_inc;
                count_reg[sel_lvl] <= count_upd;
            end
            if (do_pop)
            begin
                head_reg[sel_lvl]  <= unit_ptr_inc;
                count_reg[sel_lvl] <= count_upd;
            end
            if (do_finish)
            begin
                done_reg[req_lvl][fin_inst] <= 1'b0;
            end
            if (set_done)
            begin
                done_reg[pop_lvl_reg][INST_W'(rdata_reg.inst)] <= 1'b1;
            end
        end
    end

endmodule : strict_priority_command_queue_unit
`default_nettype wire

### hdl/scq_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scq_checker - port-level checks for the strict priority command queue
// Watches the command and response ports; bound to the top level below.
// ----------------------------------------------------------------------------
module scq_checker
    import scq_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic rsp_valid,
    input wire rsp_t rsp
);

    // An accepted item raises busy after it is taken
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted item");

    // A result is a single-cycle strobe
    a_rsp_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |=> !rsp_valid)
        else $error("response strobe longer than one cycle");

    // Busy drops exactly when the result shows
    a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> rsp_valid)
        else $error("busy dropped without a response");

    a_rsp_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !busy)
        else $error("response shown while still busy");

    // Only popped entries carry payload
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !(rsp.status == ST_DISPATCHED || rsp.status == ST_OWNER_GONE
                       || rsp.status == ST_WITHDRAWN)
        |-> (rsp.out_priority == '0) && (rsp.out_inst_index == '0)
            && (rsp.out_core_index == '0) && (rsp.out_codec_mode == '0)
            && (rsp.out_owner_id == '0))
        else $error("payload set on a response without an entry");

endmodule : scq_checker

bind strict_priority_command_queue_unit scq_checker u_scq_checker (.*);
`default_nettype wire

### dv/strict_priority_command_queue_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// strict_priority_command_queue_unit_tb - command scheduler testbench
// Drives submit, dispatch, withdraw, finish and owner requests through the
// start/busy port. A behavioral copy of the per-level FIFOs, done flags and
// owner set predicts every response, and each strobed response is checked
// field by field in order. Directed cases come first, then random traffic
// over hot levels with prio_enable switched between phases.
// ----------------------------------------------------------------------------
module strict_priority_command_queue_unit_tb;
    import scq_pkg::*;

    localparam int NUM_LEVELS    = 32;
    localparam int LEVEL_DEPTH   = 8;
    localparam int NUM_INSTANCES = 32;
    localparam int NUM_OWNERS    = 64;

    // request codes with no operation behind them
    localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
    localparam logic [2:0] REQ_UNUSED_7 = 3'd7;

    localparam int ITEMS_PER_PHASE = 305;
    localparam int NUM_PHASES      = 6;
    localparam int MAX_PRINTED     = 100;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic start     = 1'b0;
    logic busy;
    cmd_t cmd       = '0;
    logic cfg_we    = 1'b0;
    logic cfg_wdata = 1'b0;
    logic rsp_valid;
    rsp_t rsp;

    // scheduler state as the design should hold it
    entry_t      lvl_store [NUM_LEVELS][LEVEL_DEPTH];
    int          lvl_head  [NUM_LEVELS];
    int          lvl_tail  [NUM_LEVELS];
    int          lvl_count [NUM_LEVELS];
    logic [31:0] done_bits [NUM_LEVELS];
    logic [63:0] live_owners;
    bit          seen_submit;
    logic        prio_on;

    rsp_t        expected_rsp_q [$];
    int          mismatch_count = 0;
    int          burst_left     = 0;
    logic [4:0]  hot_levels [3];

    strict_priority_command_queue_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("status: fail");
        $finish;
    end

    function automatic rsp_t predict_response(input cmd_t c);
        rsp_t   r;
        entry_t e;
        int     lvl;
        bit     found;
        r        = '0;
        r.status = ST_EMPTY;
        lvl      = c.priority_req;
        found    = 1'b0;
        case (c.req_type)
            REQ_SUBMIT:
            begin
                if (lvl >= NUM_LEVELS || int'(c.inst_index) >= NUM_INSTANCES)
                    r.status = ST_DROPPED;
                else if (!seen_submit || !prio_on)
                begin
                    seen_submit = 1'b1;
                    r.status    = ST_BYPASS;
                end
                else if (lvl_count[lvl] >= LEVEL_DEPTH)
                    r.status = ST_DROPPED;
                else
                begin
                    e.inst  = c.inst_index;
                    e.core  = c.core_index;
                    e.mode  = c.codec_mode;
                    e.owner = c.owner_id;
                    lvl_store[lvl][lvl_tail[lvl]] = e;
                    lvl_tail[lvl]  = (lvl_tail[lvl] + 1) % LEVEL_DEPTH;
                    lvl_count[lvl] = lvl_count[lvl] + 1;
                    r.status = ST_QUEUED;
                end
            end
            REQ_DISPATCH, REQ_WITHDRAW:
            begin
                // dispatch serves the highest non-empty level
                if (c.req_type == REQ_DISPATCH)
                begin
                    for (int i = NUM_LEVELS - 1; i >= 0; i--)
                    begin
                        if (!found && lvl_count[i] != 0)
                        begin
                            found = 1'b1;
                            lvl   = i;
                        end
                    end
                end
                else
                    found = (lvl < NUM_LEVELS) && (lvl_count[lvl] != 0);
                if (found)
                begin
                    e = lvl_store[lvl][lvl_head[lvl]];
                    lvl_head[lvl]  = (lvl_head[lvl] + 1) % LEVEL_DEPTH;
                    lvl_count[lvl] = lvl_count[lvl] - 1;
                    if (c.req_type == REQ_WITHDRAW)
                        r.status = ST_WITHDRAWN;
                    else if (int'(e.owner) < NUM_OWNERS && live_owners[e.owner])
                    begin
                        done_bits[lvl][e.inst] = 1'b1;
                        r.status = ST_DISPATCHED;
                    end
                    else
                        r.status = ST_OWNER_GONE;
                    r.out_priority   = 5'(lvl);
                    r.out_inst_index = e.inst;
                    r.out_core_index = e.core;
                    r.out_codec_mode = e.mode;
                    r.out_owner_id   = e.owner;
                end
            end
            REQ_FINISH:
            begin
                r.status = ST_NOT_DONE;
                if (lvl < NUM_LEVELS && int'(c.inst_index) < NUM_INSTANCES)
                begin
                    if (done_bits[lvl][c.inst_index])
                        r.status = ST_DONE;
                    done_bits[lvl][c.inst_index] = 1'b0;
                end
            end
            REQ_ATTACH:
            begin
                if (int'(c.owner_id) < NUM_OWNERS)
                    live_owners[c.owner_id] = 1'b1;
                r.status = ST_OWNER_UPD;
            end
            REQ_DETACH:
            begin
                if (int'(c.owner_id) < NUM_OWNERS)
                    live_owners[c.owner_id] = 1'b0;
                r.status = ST_OWNER_UPD;
            end
            default:
                r.status = ST_EMPTY;
        endcase
        return r;
    endfunction

    function automatic cmd_t make_cmd(input logic [2:0] req, input logic [4:0] lvl,
                                      input logic [4:0] inst, input logic [1:0] core,
                                      input logic [3:0] mode, input logic [5:0] owner);
        cmd_t c;
        c.req_type     = req_t'(req);
        c.priority_req = lvl;
        c.inst_index   = inst;
        c.core_index   = core;
        c.codec_mode   = mode;
        c.owner_id     = owner;
        return c;
    endfunction

    function automatic cmd_t random_cmd();
        int         pick;
        logic [2:0] req;
        logic [4:0] lvl;
        logic [4:0] inst;
        logic [5:0] owner;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            req = REQ_SUBMIT;
        else if (pick < 60)
            req = REQ_DISPATCH;
        else if (pick < 70)
            req = REQ_WITHDRAW;
        else if (pick < 82)
            req = REQ_FINISH;
        else if (pick < 90)
            req = REQ_ATTACH;
        else if (pick < 96)
            req = REQ_DETACH;
        else if (pick < 98)
            req = REQ_UNUSED_6;
        else
            req = REQ_UNUSED_7;
        // mostly hot levels, few instances and owners so queues fill and flags hit
        if ($urandom_range(0, 9) < 7)
            lvl = hot_levels[$urandom_range(0, 2)];
        else
            lvl = 5'($urandom_range(0, 31));
        if ($urandom_range(0, 9) < 7)
            inst = 5'($urandom_range(0, 3));
        else
            inst = 5'($urandom_range(0, 31));
        if ($urandom_range(0, 9) < 7)
            owner = 6'($urandom_range(0, 7));
        else
            owner = 6'($urandom_range(0, 63));
        return make_cmd(req, lvl, inst, 2'($urandom_range(0, 3)),
                        4'($urandom_range(0, 15)), owner);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    always @(posedge clk)
    begin : check_responses
        rsp_t want;
        if (rst_n && rsp_valid === 1'b1)
        begin
            if (expected_rsp_q.size() == 0)
                report_mismatch("response with nothing outstanding");
            else
            begin
                want = expected_rsp_q.pop_front();
                check_field("status", rsp.status, want.status);
                check_field("out_priority", rsp.out_priority, want.out_priority);
                check_field("out_inst_index", rsp.out_inst_index, want.out_inst_index);
                check_field("out_core_index", rsp.out_core_index, want.out_core_index);
                check_field("out_codec_mode", rsp.out_codec_mode, want.out_codec_mode);
                check_field("out_owner_id", rsp.out_owner_id, want.out_owner_id);
            end
        end
    end

    task automatic wait_drained();
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    // hold start high until the item is taken, then log its response
    task automatic send_item(input cmd_t c);
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_rsp_q.push_back(predict_response(c));
    endtask

    // bursts of items with random gaps; now and then drain everything
    task automatic pace_sender();
        int gap;
        bit hold_all;
        gap      = 0;
        hold_all = ($urandom_range(0, 149) == 0);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
        end
        if (gap > 0 || hold_all)
            start <= 1'b0;
        if (hold_all)
            wait_drained();
        repeat (gap) @(posedge clk);
    endtask

    task automatic send_paced(input cmd_t c);
        send_item(c);
        pace_sender();
    endtask

    task automatic write_prio_enable(input logic value);
        start <= 1'b0;
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we  <= 1'b0;
        prio_on  = value;
    endtask

    task automatic test_idle_requests();
        write_prio_enable(1'b1);
        send_paced(make_cmd(REQ_DISPATCH, 5'd0, 5'd0, 2'd0, 4'd0, 6'd0));
        send_paced(make_cmd(REQ_WITHDRAW, 5'd31, 5'd0, 2'd0, 4'd0, 6'd0));
        send_paced(make_cmd(REQ_FINISH, 5'd0, 5'd0, 2'd0, 4'd0, 6'd0));
        send_paced(make_cmd(REQ_UNUSED_6, 5'd31, 5'd31, 2'd3, 4'd15, 6'd63));
        send_paced(make_cmd(REQ_UNUSED_7, 5'd0, 5'd0, 2'd0, 4'd0, 6'd0));
        // first submit bypasses even with priority mode on
        send_paced(make_cmd(REQ_SUBMIT, 5'd5, 5'd7, 2'd1, 4'd9, 6'd3));
    endtask

    task automatic test_owner_tracking();
        send_paced(make_cmd(REQ_ATTACH, 5'd0, 5'd0, 2'd0, 4'd0, 6'd63));
        send_paced(make_cmd(REQ_SUBMIT, 5'd31, 5'd31, 2'd3, 4'd15, 6'd63));
        send_paced(make_cmd(REQ_SUBMIT, 5'd0, 5'd0, 2'd0, 4'd0, 6'd0));
        send_paced(make_cmd(REQ_DISPATCH, 5'd0, 5'd0, 2'd0, 4'd0, 6'd0));
        send_paced(make_cmd(REQ_DISPATCH, 5'd31, 5'd31, 2'd3, 4'd15, 6'd63));
        send_paced(make_cmd(REQ_FINISH, 5'd31, 5'd31, 2'd0, 4'd0, 6'd0));
        send_paced(make_cmd(REQ_FINISH, 5'd31, 5'd31, 2'd0, 4'd0, 6'd0));
        send_paced(make_cmd(REQ_DETACH, 5'd0, 5'd0, 2'd0, 4'd0, 6'd63));
    endtask

    task automatic test_level_full();
        // nine into one level: the last one finds it full
        for (int i = 0; i < LEVEL_DEPTH + 1; i++)
            send_paced(make_cmd(REQ_SUBMIT, 5'd17, 5'(i), 2'(i), 4'(i), 6'(i)));
        send_paced(make_cmd(REQ_WITHDRAW, 5'd17, 5'd0, 2'd0, 4'd0, 6'd0));
    endtask

    task automatic test_random_traffic();
        logic prio_setting [NUM_PHASES];
        prio_setting = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_prio_enable(prio_setting[p]);
            hot_levels = '{5'd0, 5'd31, 5'($urandom_range(1, 30))};
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_paced(random_cmd());
        end
    endtask

    initial
    begin
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            lvl_head[l]  = 0;
            lvl_tail[l]  = 0;
            lvl_count[l] = 0;
            done_bits[l] = '0;
        end
        live_owners = '0;
        seen_submit = 1'b0;
        prio_on     = 1'b0;
        hot_levels  = '{5'd0, 5'd31, 5'd17};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_requests();
        test_owner_tracking();
        test_level_full();
        test_random_traffic();
        start <= 1'b0;
        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### files.f
hdl/scq_pkg.sv
hdl/strict_priority_command_queue_unit.sv
hdl/scq_checker.sv
dv/strict_priority_command_queue_unit_tb.sv
